/* design/wmdr_pkg.sv */
// Shared types and constants for the windowed mean deadband reporter.
`timescale 1ns / 1ps
package wmdr_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned HYST_W     = 31;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DIV_STEP_W = 6;

  localparam logic [CNT_W-1:0]      MAX_WINDOW_SAMPLES = 16'hFFFF;
  localparam logic [DIV_STEP_W-1:0] DIV_LAST           = DIV_STEP_W'(SUM_W - 1);
  localparam logic [DATA_W-1:0]     INTERVAL_RST       = 32'd1000;
  localparam logic [HYST_W-1:0]     HYST_RST           = '0;

  // Register index, taken from paddr[2]
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_HYST     = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ACCUM = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_FIX   = 6'b010000,
    ST_CHECK = 6'b100000
  } state_e;

  typedef struct packed {
    logic capture;
    logic accum;
    logic load;
    logic div_step;
    logic fix;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic div_done;
    logic report;
    logic out_free;
  } sts_t;

endpackage

/* design/wmdr_regs.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module wmdr_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wmdr_pkg::ADDR_W-1:0]        paddr,
  input  logic [wmdr_pkg::DATA_W-1:0]        pwdata,
  output logic [wmdr_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  output logic [wmdr_pkg::DATA_W-1:0]        interval_o,
  output logic [wmdr_pkg::HYST_W-1:0]        hyst_o
);

  logic [wmdr_pkg::DATA_W-1:0] interval_q;
  logic [wmdr_pkg::HYST_W-1:0] hyst_q;
  logic                        wr_en;
  logic                        sel;

  assign pready = 1'b1;
  assign sel    = paddr[2];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= wmdr_pkg::INTERVAL_RST;
      hyst_q     <= wmdr_pkg::HYST_RST;
    end else if (wr_en) begin
      case (sel)
        wmdr_pkg::REG_INTERVAL: interval_q <= pwdata;
        wmdr_pkg::REG_HYST:     hyst_q     <= pwdata[wmdr_pkg::HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      wmdr_pkg::REG_INTERVAL: prdata = interval_q;
      wmdr_pkg::REG_HYST:     prdata = {1'b0, hyst_q};
      default:                prdata = '0;
    endcase
  end

  assign interval_o = interval_q;
  assign hyst_o     = hyst_q;

endmodule

/* design/wmdr_ctrl.sv */
// Sequencer: accumulate, window close, divide, deadband check, report.
`timescale 1ns / 1ps
module wmdr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 sample_valid_i,
  input  logic                 sample_finite_i,
  output logic                 sample_ready_o,
  input  wmdr_pkg::sts_t       sts_i,
  output wmdr_pkg::cmd_t       cmd_o
);

  wmdr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmdr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign sample_ready_o = (state_q == wmdr_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      wmdr_pkg::ST_IDLE: begin
        // drop non-finite words on the spot
        if (sample_valid_i && sample_finite_i) begin
          cmd_o.capture = 1'b1;
          state_d       = wmdr_pkg::ST_ACCUM;
        end
      end
      wmdr_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = sts_i.close ? wmdr_pkg::ST_LOAD : wmdr_pkg::ST_IDLE;
      end
      wmdr_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = wmdr_pkg::ST_DIV;
      end
      wmdr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = wmdr_pkg::ST_FIX;
        end
      end
      wmdr_pkg::ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = wmdr_pkg::ST_CHECK;
      end
      wmdr_pkg::ST_CHECK: begin
        // hold while a report is due and the output word is still unread
        if (!(sts_i.report && !sts_i.out_free)) begin
          cmd_o.commit = 1'b1;
          state_d      = wmdr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wmdr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/wmdr_dp.sv */
// Datapath: window sum and count, restoring divider, deadband compare, output word.
`timescale 1ns / 1ps
module wmdr_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [wmdr_pkg::DATA_W-1:0] sample_value_i,
  input  logic        [wmdr_pkg::DATA_W-1:0] time_ms_i,
  input  logic        [wmdr_pkg::DATA_W-1:0] interval_i,
  input  logic        [wmdr_pkg::HYST_W-1:0] hyst_i,
  input  wmdr_pkg::cmd_t                     cmd_i,
  output wmdr_pkg::sts_t                     sts_o,
  output logic signed [wmdr_pkg::DATA_W-1:0] report_value_o,
  output logic                               report_valid_o,
  input  logic                               report_ready_i
);

  localparam int unsigned DW = wmdr_pkg::DATA_W;
  localparam int unsigned SW = wmdr_pkg::SUM_W;
  localparam int unsigned CW = wmdr_pkg::CNT_W;

  logic signed [DW-1:0] smp_q;
  logic        [DW-1:0] time_q;
  logic signed [SW-1:0] sum_q;
  logic        [CW-1:0] cnt_q;
  logic        [DW-1:0] start_q;
  logic signed [DW-1:0] last_q;
  logic        [SW-1:0] dvd_q;
  logic        [CW-1:0] rem_q;
  logic        [CW-1:0] dvs_q;
  logic                 neg_q;
  logic [wmdr_pkg::DIV_STEP_W-1:0] step_q;
  logic signed [DW-1:0] mean_q;
  logic signed [DW-1:0] out_q;
  logic                 out_valid_q;

  logic        [DW-1:0] elapsed;
  logic        [CW:0]   trial_rem;
  logic        [CW:0]   trial_sub;
  logic                 trial_ge;
  logic signed [DW:0]   diff;
  logic signed [DW:0]   hyst_pos;
  logic signed [DW:0]   hyst_neg;
  logic                 load_out;

  assign elapsed = time_q - start_q;

  // one quotient bit per cycle
  assign trial_rem = {rem_q, dvd_q[SW-1]};
  assign trial_sub = trial_rem - {1'b0, dvs_q};
  assign trial_ge  = ~trial_sub[CW];

  assign diff     = {mean_q[DW-1], mean_q} - {last_q[DW-1], last_q};
  assign hyst_pos = {2'b00, hyst_i};
  assign hyst_neg = -hyst_pos;

  assign sts_o.close    = (elapsed > interval_i);
  assign sts_o.div_done = (step_q == wmdr_pkg::DIV_LAST);
  assign sts_o.report   = (hyst_i == '0) || (diff >= hyst_pos) || (diff <= hyst_neg);
  assign sts_o.out_free = ~out_valid_q | report_ready_i;

  assign load_out = cmd_i.commit & sts_o.report;

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      start_q <= '0;
      last_q  <= '0;
    end else begin
      if (cmd_i.accum && (cnt_q != wmdr_pkg::MAX_WINDOW_SAMPLES)) begin
        sum_q <= sum_q + SW'(smp_q);
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.load) begin
        sum_q   <= '0;
        cnt_q   <= '0;
        start_q <= time_q;
      end
      if (load_out) begin
        last_q <= mean_q;
      end
    end
  end

  // captured word and divider, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q  <= sample_value_i;
      time_q <= time_ms_i;
    end
    if (cmd_i.load) begin
      neg_q  <= sum_q[SW-1];
      dvd_q  <= sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
      dvs_q  <= cnt_q;
      rem_q  <= '0;
      step_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? trial_sub[CW-1:0] : trial_rem[CW-1:0];
      dvd_q  <= {dvd_q[SW-2:0], trial_ge};
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.fix) begin
      // quotient magnitude is at most 2^31, so the low word carries the mean
      mean_q <= neg_q ? DW'(-dvd_q[DW-1:0]) : DW'(dvd_q[DW-1:0]);
    end
    if (load_out) begin
      out_q <= mean_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (report_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign report_value_o = out_q;
  assign report_valid_o = out_valid_q;

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (cnt_q == '0) && (sum_q == '0))
    else $error("window not cleared after close");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || report_ready_i))
    else $error("pending output word overwritten");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (step_q <= wmdr_pkg::DIV_LAST))
    else $error("divider ran past its last step");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (cnt_q != '0))
    else $error("window closed with no samples");

endmodule

/* design/windowed_mean_deadband_reporter_unit.sv */
// Top level of the windowed mean deadband reporter.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  sample   | sample_valid_i/ready_o      | sample_value_i, sample_finite_i, time_ms_i
//  report   | report_valid_o/ready_i      | report_value_o
//  config   | psel, penable, pwrite       | paddr, pwdata, prdata, pready
//
// IDLE drops a non-finite word; a finite word that keeps the window open goes via ACCUM.
// A window close runs capture and accumulate with the close compare, a divider load, the
// one-bit-per-cycle restoring divider, a sign fix and the deadband check.
// rst_ni clears the window state at once; there is no clearing pass.
// A report due while the output register is still unread holds the check step.
`timescale 1ns / 1ps
module windowed_mean_deadband_reporter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               sample_valid_i,
  output logic                               sample_ready_o,
  input  logic signed [wmdr_pkg::DATA_W-1:0] sample_value_i,
  input  logic                               sample_finite_i,
  input  logic        [wmdr_pkg::DATA_W-1:0] time_ms_i,
  output logic                               report_valid_o,
  input  logic                               report_ready_i,
  output logic signed [wmdr_pkg::DATA_W-1:0] report_value_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [wmdr_pkg::ADDR_W-1:0] paddr,
  input  logic        [wmdr_pkg::DATA_W-1:0] pwdata,
  output logic        [wmdr_pkg::DATA_W-1:0] prdata,
  output logic                               pready
);

  logic [wmdr_pkg::DATA_W-1:0] interval;
  logic [wmdr_pkg::HYST_W-1:0] hyst;
  wmdr_pkg::cmd_t              cmd;
  wmdr_pkg::sts_t              sts;

  wmdr_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .interval_o (interval),
    .hyst_o     (hyst)
  );

  wmdr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_valid_i  (sample_valid_i),
    .sample_finite_i (sample_finite_i),
    .sample_ready_o  (sample_ready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  wmdr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_value_i (sample_value_i),
    .time_ms_i      (time_ms_i),
    .interval_i     (interval),
    .hyst_i         (hyst),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .report_value_o (report_value_o),
    .report_valid_o (report_valid_o),
    .report_ready_i (report_ready_i)
  );

endmodule

/* bench/wmdr_report_checker.sv */
// Scoreboard for the windowed mean deadband reporter: predicts reports and compares them.
`timescale 1ns / 1ps
module wmdr_report_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                sample_valid_i,
  input  logic                                sample_ready_i,
  input  logic signed [wmdr_pkg::DATA_W-1:0]  sample_value_i,
  input  logic                                sample_finite_i,
  input  logic        [wmdr_pkg::DATA_W-1:0]  time_ms_i,
  input  logic                                report_valid_i,
  input  logic                                report_ready_i,
  input  logic signed [wmdr_pkg::DATA_W-1:0]  report_value_i,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [wmdr_pkg::ADDR_W-1:0]  paddr,
  input  logic        [wmdr_pkg::DATA_W-1:0]  pwdata,
  input  logic                                pready,
  output int unsigned                         mismatch_count_o,
  output int unsigned                         reports_pending_o
);

  localparam int unsigned DW = wmdr_pkg::DATA_W;
  localparam int unsigned SW = wmdr_pkg::SUM_W;
  localparam int unsigned CW = wmdr_pkg::CNT_W;
  localparam int unsigned HW = wmdr_pkg::HYST_W;

  logic        [DW-1:0] interval_ms;
  logic        [HW-1:0] deadband;
  logic signed [SW-1:0] win_sum;
  logic        [CW-1:0] win_count;
  logic        [DW-1:0] win_start_ms;
  logic signed [DW-1:0] last_report;
  logic signed [DW-1:0] pending_means[$];
  logic signed [DW-1:0] oldest_mean;
  int unsigned          mismatches = 0;

  // Fold one accepted word into the window; queue the mean if the window closes and reports.
  task automatic fold_sample(input logic signed [DW-1:0] value, input logic finite,
                             input logic [DW-1:0] now_ms);
    longint         mean;
    longint         gap;
    logic [DW-1:0]  elapsed;
    if (!finite) return;
    if (win_count < wmdr_pkg::MAX_WINDOW_SAMPLES) begin
      win_sum   = SW'(longint'(win_sum) + longint'(value));
      win_count = win_count + 1'b1;
    end
    elapsed = now_ms - win_start_ms;
    if (elapsed <= interval_ms) return;
    win_start_ms = now_ms;
    // signed longint division truncates toward zero
    mean      = (win_count != '0) ? longint'(win_sum) / longint'(win_count) : 0;
    win_sum   = '0;
    win_count = '0;
    gap = mean - longint'(last_report);
    if (gap < 0) gap = -gap;
    if (deadband == '0 || gap >= longint'(deadband)) begin
      last_report = DW'(mean);
      pending_means.insert(pending_means.size(), DW'(mean));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_ms  = wmdr_pkg::INTERVAL_RST;
      deadband     = wmdr_pkg::HYST_RST;
      win_sum      = '0;
      win_count    = '0;
      win_start_ms = '0;
      last_report  = '0;
      pending_means.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          wmdr_pkg::REG_INTERVAL: interval_ms = pwdata;
          wmdr_pkg::REG_HYST:     deadband    = pwdata[HW-1:0];
          default: ;
        endcase
      end
      if (sample_valid_i && sample_ready_i) begin
        fold_sample(sample_value_i, sample_finite_i, time_ms_i);
      end
      if (report_valid_i && report_ready_i) begin
        if (pending_means.size() == 0) begin
          mismatches++;
          $error("report_value: expected no word, got %0d", report_value_i);
        end else begin
          oldest_mean = pending_means.pop_front();
          if (report_value_i !== oldest_mean) begin
            mismatches++;
            $error("report_value: expected %0d, got %0d", oldest_mean, report_value_i);
          end
        end
      end
    end
    mismatch_count_o  = mismatches;
    reports_pending_o = pending_means.size();
  end

endmodule

/* bench/windowed_mean_deadband_reporter_unit_tb.sv */
// Testbench top for the windowed mean deadband reporter: stimulus, idling and verdict.
`timescale 1ns / 1ps
module windowed_mean_deadband_reporter_unit_tb;

  localparam int unsigned        DW            = wmdr_pkg::DATA_W;
  localparam int unsigned        AW            = wmdr_pkg::ADDR_W;
  localparam int unsigned        HW            = wmdr_pkg::HYST_W;
  localparam int unsigned        CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned        PHASE_WORDS   = 185;
  localparam int unsigned        LONG_WINDOW   = 40;
  localparam int unsigned        SETTLE_CYCLES = 100;
  localparam logic signed [31:0] FULL_POS      = 32'sh7FFFFFFF;
  localparam logic signed [31:0] FULL_NEG      = 32'sh80000000;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  sample_valid_i  = 1'b0;
  logic                  sample_ready_o;
  logic signed [DW-1:0]  sample_value_i  = '0;
  logic                  sample_finite_i = 1'b0;
  logic        [DW-1:0]  time_ms_i       = '0;
  logic                  report_valid_o;
  logic                  report_ready_i  = 1'b0;
  logic signed [DW-1:0]  report_value_o;
  logic                  psel            = 1'b0;
  logic                  penable         = 1'b0;
  logic                  pwrite          = 1'b0;
  logic        [AW-1:0]  paddr           = '0;
  logic        [DW-1:0]  pwdata          = '0;
  logic        [DW-1:0]  prdata;
  logic                  pready;

  int unsigned           mismatch_count;
  int unsigned           reports_pending;
  int unsigned           cycles    = 0;
  int unsigned           idle_pct  = 0;
  int unsigned           stall_pct = 0;
  logic        [DW-1:0]  now_ms;
  logic        [DW-1:0]  interval_ms;
  logic        [HW-1:0]  deadband;
  logic signed [DW-1:0]  level;

  windowed_mean_deadband_reporter_unit u_dut (
    .clk_i, .rst_ni,
    .sample_valid_i, .sample_ready_o, .sample_value_i, .sample_finite_i, .time_ms_i,
    .report_valid_o, .report_ready_i, .report_value_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  wmdr_report_checker u_checker (
    .clk_i, .rst_ni,
    .sample_valid_i, .sample_ready_i(sample_ready_o), .sample_value_i, .sample_finite_i,
    .time_ms_i,
    .report_valid_i(report_valid_o), .report_ready_i, .report_value_i(report_value_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_count_o(mismatch_count), .reports_pending_o(reports_pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL windowed_mean_deadband_reporter_unit");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_ready_i <= 1'b0;
    end else begin
      report_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one word; hold valid and payload until the handshake.
  task automatic send_word(input logic signed [DW-1:0] value, input logic finite,
                           input logic [DW-1:0] stamp);
    if ($urandom_range(0, 99) < idle_pct) begin
      sample_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    sample_valid_i  <= 1'b1;
    sample_value_i  <= value;
    sample_finite_i <= finite;
    time_ms_i       <= stamp;
    @(posedge clk_i);
    while (!sample_ready_o) @(posedge clk_i);
  endtask

  // Drop valid, wait for every queued report, then let a silent window close finish.
  task automatic drain_reports();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reports_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Half the words near a level, the rest anywhere; time mostly steps, sometimes jumps.
  task automatic send_random_word();
    logic signed [DW-1:0] value;
    logic        [DW-1:0] step_max;
    int unsigned          pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      value = level + DW'($urandom_range(0, 32'h40000)) - 32'h20000;
    end else if (pick < 75) begin
      value = $urandom;
    end else if (pick < 85) begin
      value = pick[0] ? FULL_POS : FULL_NEG;
    end else begin
      value = DW'($urandom_range(0, 32'h1FFFF)) - 32'h10000;
    end
    step_max = (interval_ms < 32'd5000) ? 2 * interval_ms + 2 : 32'd5000;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      now_ms = now_ms + $urandom_range(0, step_max);
    end else if (pick < 80) begin
      now_ms = now_ms + interval_ms + $urandom_range(0, 1);
    end else if (pick < 90) begin
      now_ms = $urandom;
    end
    send_word(value, $urandom_range(0, 99) < 88, now_ms);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: interval 1000, deadband off
    send_word(-32'sd1, 1'b0, 32'd5000);       // non-finite, ignored even past the interval
    send_word(FULL_POS, 1'b1, 32'd1000);      // elapsed equals interval: stays open
    send_word(FULL_POS, 1'b1, 32'd1001);
    send_word(FULL_NEG, 1'b1, 32'd1500);
    send_word(FULL_NEG, 1'b1, 32'd2002);
    send_word(-32'sd3, 1'b1, 32'd2100);       // mean -1/2 truncates to zero
    send_word(32'sd2, 1'b1, 32'd3003);
    send_word(-32'sd7, 1'b1, 32'd3100);       // mean -7/2 truncates to -3
    send_word(32'sd0, 1'b1, 32'd4004);
    send_word(32'sd5, 1'b1, 32'hFFFF_FFF0);
    send_word(32'sd7, 1'b1, 32'h0000_0100);   // timestamp wraps
    send_word(32'sd9, 1'b1, 32'h0000_03F8);
    send_word(32'sd0, 1'b0, 32'h8000_0000);
    drain_reports();

    // zero interval, widest deadband
    write_reg(wmdr_pkg::REG_INTERVAL, 32'd0);
    write_reg(wmdr_pkg::REG_HYST, {1'b0, 31'h7FFF_FFFF});
    send_word(FULL_NEG, 1'b1, 32'h3F8);       // same time: no close
    send_word(FULL_NEG, 1'b1, 32'h3F9);
    send_word(FULL_POS, 1'b1, 32'h3FA);
    send_word(FULL_POS - 1, 1'b1, 32'h3FB);   // inside the deadband
    send_word(32'sd0, 1'b1, 32'h3FC);         // exactly on the deadband edge
    drain_reports();

    write_reg(wmdr_pkg::REG_HYST, {1'b0, 31'h0001_0000});
    send_word(32'sh0000_FFFF, 1'b1, 32'h3FD);
    send_word(32'sh0001_0000, 1'b1, 32'h3FE);
    send_word(32'sd0, 1'b1, 32'h3FF);
    drain_reports();

    // long window with the interval at maximum: nothing closes until it drops
    write_reg(wmdr_pkg::REG_INTERVAL, 32'hFFFF_FFFF);
    write_reg(wmdr_pkg::REG_HYST, '0);
    repeat (LONG_WINDOW) send_word(FULL_POS, 1'b1, $urandom);
    repeat (5) send_word(FULL_NEG, 1'b1, $urandom);
    drain_reports();
    write_reg(wmdr_pkg::REG_INTERVAL, 32'd0);
    send_word(FULL_NEG, 1'b1, 32'h400);
    drain_reports();

    now_ms = 32'h400;
    for (int unsigned phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      case (phase)
        0: begin interval_ms = 32'd0;                  deadband = '0;          end
        1: begin interval_ms = $urandom_range(1, 8);    deadband = HW'($urandom_range(1, 32'h30000)); end
        2: begin interval_ms = $urandom_range(9, 60);   deadband = 31'h7FFF_FFFF; end
        3: begin interval_ms = 32'd1000;               deadband = '0;          end
        4: begin interval_ms = $urandom_range(61, 400); deadband = HW'($urandom_range(32'h8000, 32'h20000)); end
        5: begin interval_ms = 32'hFFFF_FFFE;          deadband = '0;          end
        6: begin interval_ms = $urandom_range(1, 20);   deadband = HW'($urandom_range(1, 32'h7FFF_FFFF)); end
        default: begin interval_ms = $urandom_range(2000, 4000); deadband = HW'($urandom_range(1, 32'h10000)); end
      endcase
      level = DW'($urandom_range(0, 32'h00A0_0000)) - 32'h0050_0000;
      drain_reports();
      write_reg(wmdr_pkg::REG_INTERVAL, interval_ms);
      write_reg(wmdr_pkg::REG_HYST, {1'b0, deadband});
      repeat (PHASE_WORDS) send_random_word();
    end

    drain_reports();
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("PASS windowed_mean_deadband_reporter_unit");
    end else begin
      $display("FAIL windowed_mean_deadband_reporter_unit");
    end
    $finish;
  end

endmodule

/* sim.f */
design/wmdr_pkg.sv
design/wmdr_regs.sv
design/wmdr_ctrl.sv
design/wmdr_dp.sv
design/windowed_mean_deadband_reporter_unit.sv
bench/wmdr_report_checker.sv
bench/windowed_mean_deadband_reporter_unit_tb.sv
